>>> sv/gcd_pair_counter_core_defines.svh
// assertion macros shared by the gcd pair counter checker
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef GCD_PAIR_COUNTER_CORE_DEFINES_SVH
`define GCD_PAIR_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GCDPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define GCDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gcdpc_pkg.sv
// shared types and constants of the gcd pair counter
// no dependencies
`default_nettype none

package gcdpc_pkg;

  // payload widths of the channels
  localparam int unsigned FieldW = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned AccW   = 64;

  // moebius table entry: {composite, large factor, mu}
  localparam int unsigned MuW        = 4;
  localparam int unsigned MuBitComp  = 3;
  localparam int unsigned MuBitLarge = 2;

  typedef logic [1:0] mu_t;

  localparam mu_t MU_ZERO = 2'b00;
  localparam mu_t MU_POS  = 2'b01;

  // two's complement negate of a mu value
  function automatic mu_t mu_neg(input mu_t v);
    return mu_t'(~v + 2'd1);
  endfunction

endpackage

`default_nettype wire

>>> sv/gcdpc_if.sv
// request and response channel interfaces of the gcd pair counter
// depends on gcdpc_pkg
`default_nettype none

interface gcdpc_req_if;
  import gcdpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] x_low;
  logic [FieldW-1:0] x_high;
  logic [FieldW-1:0] y_low;
  logic [FieldW-1:0] y_high;
  logic [FieldW-1:0] gcd_target;

  modport source (output valid, x_low, x_high, y_low, y_high, gcd_target, input ready);
  modport sink (input valid, x_low, x_high, y_low, y_high, gcd_target, output ready);
endinterface

interface gcdpc_rsp_if;
  import gcdpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] pair_count;
  logic              range_error;

  modport source (output valid, pair_count, range_error, input ready);
  modport sink (input valid, pair_count, range_error, output ready);
endinterface

`default_nettype wire

>>> sv/gcdpc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gcdpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/gcdpc_div.sv
// shared restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module gcdpc_div #(
  parameter int unsigned Width = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic      [Width-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] quot_q, quot_d;
  logic [Width-1:0] dsr_q, dsr_d;
  logic [Width:0]   trial;

  // one restoring step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quot_q[Width-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Width);
      rem_d  = '0;
      quot_d = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = Width'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[Width-2:0], 1'b1};
      end else begin
        rem_d  = trial[Width-1:0];
        quot_d = {quot_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> sv/gcdpc_sieve.sv
// startup sieve: builds the moebius table and writes the mertens prefix ram
// depends on gcdpc_pkg and gcdpc_ram
`default_nettype none

module gcdpc_sieve #(
  parameter int unsigned MAX_VALUE   = 65535,
  parameter int unsigned PRIME_SLOTS = 8192,
  localparam int unsigned VW = $clog2(MAX_VALUE + 1),
  localparam int unsigned MW = VW + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  output logic                      done_o,
  output logic                      mrt_we_o,
  output logic [VW-1:0]             mrt_addr_o,
  output logic signed [MW-1:0]      mrt_wdata_o
);
  import gcdpc_pkg::*;

  localparam int unsigned CntW = $clog2(PRIME_SLOTS + 1);
  localparam logic [VW:0] MaxV = (VW + 1)'(MAX_VALUE);
  localparam logic [CntW-1:0] Slots = CntW'(PRIME_SLOTS);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CHK = 9'b000000100,
    S_SWP_RD   = 9'b000001000,
    S_SWP_WR   = 9'b000010000,
    S_SQ       = 9'b000100000,
    S_MRT_RD   = 9'b001000000,
    S_MRT_WR   = 9'b010000000,
    S_DONE     = 9'b100000000
  } sieve_state_e;

  sieve_state_e        state_q, state_d;
  logic [VW:0]         idx_q, idx_d;
  logic [VW:0]         m_q, m_d;
  logic [2*VW-1:0]     sq_q, sq_d;
  logic                small_q, small_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic signed [MW-1:0] acc_q, acc_d;

  logic                mu_we;
  logic [VW-1:0]       mu_waddr;
  logic [MuW-1:0]      mu_wdata;
  logic [VW-1:0]       mu_raddr;
  logic [MuW-1:0]      mu_rdata;
  logic signed [1:0]   mu_sval;
  logic signed [MW-1:0] mrt_val;

  gcdpc_ram #(
    .Width(MuW),
    .Depth(MAX_VALUE + 1)
  ) u_mu_ram (
    .clk_i  (clk_i),
    .we_i   (mu_we),
    .waddr_i(mu_waddr),
    .wdata_i(mu_wdata),
    .raddr_i(mu_raddr),
    .rdata_o(mu_rdata)
  );

  // sieve sequencer: clear, prime scan with multiple sweeps, prefix sum
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    m_d         = m_q;
    sq_d        = sq_q;
    small_d     = small_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mu_we       = 1'b0;
    mu_waddr    = idx_q[VW-1:0];
    mu_wdata    = mu_rdata;
    mu_raddr    = idx_q[VW-1:0];
    mrt_we_o    = 1'b0;
    mu_sval     = mu_rdata[1:0];
    mrt_val     = '0;
    unique case (state_q)
      S_CLEAR: begin
        mu_we    = 1'b1;
        mu_wdata = {1'b0, 1'b0, MU_POS};
        idx_d    = idx_q + 1'b1;
        if (idx_q == MaxV) begin
          idx_d   = (VW + 1)'(2);
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_q > MaxV) begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = S_MRT_RD;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (mu_rdata[MuBitComp]) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          // primes past the slot count only mark their multiples
          small_d = (cnt_q < Slots);
          if (cnt_q < Slots) begin
            cnt_d = cnt_q + 1'b1;
          end
          m_d     = idx_q;
          sq_d    = (2 * VW)'(idx_q[VW-1:0] * idx_q[VW-1:0]);
          state_d = S_SWP_RD;
        end
      end
      S_SWP_RD: begin
        mu_raddr = m_q[VW-1:0];
        if (m_q > MaxV) begin
          if (small_q && (sq_q <= (2 * VW)'(MAX_VALUE))) begin
            m_d     = (VW + 1)'(sq_q);
            state_d = S_SQ;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_SCAN_RD;
          end
        end else begin
          state_d = S_SWP_WR;
        end
      end
      S_SWP_WR: begin
        mu_we    = 1'b1;
        mu_waddr = m_q[VW-1:0];
        mu_wdata = mu_rdata;
        if (small_q) begin
          mu_wdata[1:0] = mu_neg(mu_rdata[1:0]);
        end else begin
          mu_wdata[MuBitLarge] = 1'b1;
        end
        if (m_q != idx_q) begin
          mu_wdata[MuBitComp] = 1'b1;
        end
        m_d     = m_q + idx_q;
        state_d = S_SWP_RD;
      end
      S_SQ: begin
        // multiples of a square are composite and carry no large factor yet
        if (m_q > MaxV) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          mu_we    = 1'b1;
          mu_waddr = m_q[VW-1:0];
          mu_wdata = {1'b1, 1'b0, MU_ZERO};
          m_d      = m_q + (VW + 1)'(sq_q);
        end
      end
      S_MRT_RD: begin
        if (idx_q > MaxV) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MRT_WR;
        end
      end
      S_MRT_WR: begin
        if (mu_rdata[MuBitLarge]) begin
          mu_sval = mu_neg(mu_rdata[1:0]);
        end
        if (idx_q != '0) begin
          mrt_val = acc_q + MW'(mu_sval);
        end
        mrt_we_o = 1'b1;
        acc_d    = mrt_val;
        idx_d    = idx_q + 1'b1;
        state_d  = S_MRT_RD;
      end
      S_DONE: begin
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    sq_q    <= sq_d;
    small_q <= small_d;
    acc_q   <= acc_d;
  end

  assign done_o      = (state_q == S_DONE);
  assign mrt_addr_o  = idx_q[VW-1:0];
  assign mrt_wdata_o = mrt_val;

endmodule

`default_nettype wire

>>> sv/gcdpc_query.sv
// query sequencer: four corners, quotient blocks, one shared divider
// depends on gcdpc_pkg, gcdpc_if and gcdpc_div
`default_nettype none

module gcdpc_query #(
  parameter int unsigned MAX_VALUE = 65535,
  localparam int unsigned VW = $clog2(MAX_VALUE + 1),
  localparam int unsigned MW = VW + 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                table_ok_i,
  gcdpc_req_if.sink                req_i,
  gcdpc_rsp_if.source              rsp_o,
  output logic [VW-1:0]            mrt_addr_o,
  input  wire logic signed [MW-1:0] mrt_rdata_i
);
  import gcdpc_pkg::*;

  localparam int unsigned DW = (VW > FieldW) ? VW : FieldW;
  localparam int unsigned PW = MW + 1 + 2 * VW + 1;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_CORNER   = 11'b00000000010,
    S_DIV_GO   = 11'b00000000100,
    S_DIV_WAIT = 11'b00000001000,
    S_BLOCK    = 11'b00000010000,
    S_RD_R     = 11'b00000100000,
    S_RD_L     = 11'b00001000000,
    S_MUL1     = 11'b00010000000,
    S_MUL2     = 11'b00100000000,
    S_ACC      = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } query_state_e;

  typedef enum logic [2:0] {
    OP_A  = 3'd0,
    OP_B  = 3'd1,
    OP_QA = 3'd2,
    OP_QB = 3'd3,
    OP_RA = 3'd4,
    OP_RB = 3'd5
  } div_op_e;

  query_state_e          state_q, state_d;
  div_op_e               op_q, op_d;
  logic [1:0]            corner_q, corner_d;
  logic                  err_q, err_d;
  logic                  neg_q, neg_d;
  logic [VW-1:0]         xl_q, xl_d, xh_q, xh_d, yl_q, yl_d, yh_q, yh_d;
  logic [FieldW-1:0]     g_q, g_d;
  logic [VW-1:0]         cx_q, cx_d, cy_q, cy_d;
  logic [VW-1:0]         a_q, a_d, b_q, b_d;
  logic [VW:0]           l_q, l_d;
  logic [VW-1:0]         qa_q, qa_d, qb_q, qb_d, ra_q, ra_d, r_q, r_d;
  logic signed [MW-1:0]  mr_q, mr_d;
  logic signed [MW:0]    diff_q, diff_d;
  logic [2*VW-1:0]       p1_q, p1_d;
  logic signed [PW-1:0]  p2_q, p2_d;
  logic signed [AccW-1:0] total_q, total_d;
  logic                  out_valid_q, out_valid_d;
  logic [CountW-1:0]     out_cnt_q, out_cnt_d;
  logic                  out_err_q, out_err_d;

  logic                  div_start;
  logic [DW-1:0]         div_dividend;
  logic [DW-1:0]         div_divisor;
  logic                  div_done;
  logic [DW-1:0]         div_quot;
  logic [VW-1:0]         quot_v;
  logic [VW-1:0]         n_v;
  logic [VW-1:0]         xl_c, xh_c, yl_c, yh_c;
  logic                  req_err;
  logic signed [2*VW:0]  p1_s;

  // bound above the table is clamped to the table end
  function automatic logic [VW-1:0] clamp(input logic [FieldW-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    if (e > 32'(MAX_VALUE)) begin
      e = 32'(MAX_VALUE);
    end
    return VW'(e);
  endfunction

  gcdpc_div #(
    .Width(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // request decode: clamp, lift zero low bounds, check ranges
  always_comb begin
    xl_c = clamp(req_i.x_low);
    xh_c = clamp(req_i.x_high);
    yl_c = clamp(req_i.y_low);
    yh_c = clamp(req_i.y_high);
    if (xl_c == '0) begin
      xl_c = VW'(1);
    end
    if (yl_c == '0) begin
      yl_c = VW'(1);
    end
    req_err = (req_i.gcd_target == '0) || (xl_c > xh_c) || (yl_c > yh_c);
  end

  // divider operand select
  always_comb begin
    unique case (op_q)
      OP_A: begin
        div_dividend = DW'(cx_q);
        div_divisor  = DW'(g_q);
      end
      OP_B: begin
        div_dividend = DW'(cy_q);
        div_divisor  = DW'(g_q);
      end
      OP_QA: begin
        div_dividend = DW'(a_q);
        div_divisor  = DW'(l_q[VW-1:0]);
      end
      OP_QB: begin
        div_dividend = DW'(b_q);
        div_divisor  = DW'(l_q[VW-1:0]);
      end
      OP_RA: begin
        div_dividend = DW'(a_q);
        div_divisor  = DW'(qa_q);
      end
      OP_RB: begin
        div_dividend = DW'(b_q);
        div_divisor  = DW'(qb_q);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DW'(1);
      end
    endcase
  end

  assign quot_v = div_quot[VW-1:0];
  assign n_v    = (a_q < b_q) ? a_q : b_q;
  assign p1_s   = signed'({1'b0, p1_q});

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    corner_d    = corner_q;
    err_d       = err_q;
    neg_d       = neg_q;
    xl_d        = xl_q;
    xh_d        = xh_q;
    yl_d        = yl_q;
    yh_d        = yh_q;
    g_d         = g_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    a_d         = a_q;
    b_d         = b_q;
    l_d         = l_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    ra_d        = ra_q;
    r_d         = r_q;
    mr_d        = mr_q;
    diff_d      = diff_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    total_d     = total_q;
    out_cnt_d   = out_cnt_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    div_start   = 1'b0;
    mrt_addr_o  = r_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid && table_ok_i) begin
          xl_d     = xl_c;
          xh_d     = xh_c;
          yl_d     = yl_c;
          yh_d     = yh_c;
          g_d      = req_i.gcd_target;
          err_d    = req_err;
          corner_d = '0;
          total_d  = '0;
          state_d  = req_err ? S_DONE : S_CORNER;
        end
      end
      S_CORNER: begin
        // inclusion-exclusion over the four corners
        unique case (corner_q)
          2'd0: begin
            cx_d  = xh_q;
            cy_d  = yh_q;
            neg_d = 1'b0;
          end
          2'd1: begin
            cx_d  = xl_q - 1'b1;
            cy_d  = yh_q;
            neg_d = 1'b1;
          end
          2'd2: begin
            cx_d  = xh_q;
            cy_d  = yl_q - 1'b1;
            neg_d = 1'b1;
          end
          default: begin
            cx_d  = xl_q - 1'b1;
            cy_d  = yl_q - 1'b1;
            neg_d = 1'b0;
          end
        endcase
        op_d    = OP_A;
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_DIV_GO;
          unique case (op_q)
            OP_A: begin
              a_d  = quot_v;
              op_d = OP_B;
            end
            OP_B: begin
              b_d     = quot_v;
              l_d     = (VW + 1)'(1);
              state_d = S_BLOCK;
            end
            OP_QA: begin
              qa_d = quot_v;
              op_d = OP_QB;
            end
            OP_QB: begin
              qb_d = quot_v;
              op_d = OP_RA;
            end
            OP_RA: begin
              ra_d = quot_v;
              op_d = OP_RB;
            end
            OP_RB: begin
              r_d     = (ra_q < quot_v) ? ra_q : quot_v;
              state_d = S_RD_R;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_BLOCK: begin
        if (l_q > {1'b0, n_v}) begin
          if (corner_q == 2'd3) begin
            state_d = S_DONE;
          end else begin
            corner_d = corner_q + 1'b1;
            state_d  = S_CORNER;
          end
        end else begin
          op_d    = OP_QA;
          state_d = S_DIV_GO;
        end
      end
      S_RD_R: begin
        mrt_addr_o = r_q;
        state_d    = S_RD_L;
      end
      S_RD_L: begin
        mrt_addr_o = VW'(l_q - 1'b1);
        mr_d       = mrt_rdata_i;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        diff_d  = (MW + 1)'(mr_q) - (MW + 1)'(mrt_rdata_i);
        p1_d    = (2 * VW)'(qa_q * qb_q);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        p2_d    = PW'(diff_q) * PW'(p1_s);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (neg_q) begin
          total_d = total_q - AccW'(p2_q);
        end else begin
          total_d = total_q + AccW'(p2_q);
        end
        l_d     = {1'b0, r_q} + 1'b1;
        state_d = S_BLOCK;
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_err_d   = err_q;
          if (err_q || (total_q < 0)) begin
            out_cnt_d = '0;
          end else begin
            out_cnt_d = total_q[CountW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_A;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    neg_q     <= neg_d;
    xl_q      <= xl_d;
    xh_q      <= xh_d;
    yl_q      <= yl_d;
    yh_q      <= yh_d;
    g_q       <= g_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    a_q       <= a_d;
    b_q       <= b_d;
    l_q       <= l_d;
    qa_q      <= qa_d;
    qb_q      <= qb_d;
    ra_q      <= ra_d;
    r_q       <= r_d;
    mr_q      <= mr_d;
    diff_q    <= diff_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    total_q   <= total_d;
    out_cnt_q <= out_cnt_d;
    out_err_q <= out_err_d;
  end

  assign req_i.ready       = table_ok_i && (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pair_count  = out_cnt_q;
  assign rsp_o.range_error = out_err_q;

endmodule

`default_nettype wire

>>> sv/gcd_pair_counter_core.sv
// gcd pair counter: mertens table sieve at startup, then query sequencer
// Channels: req_i carries x_low, x_high, y_low, y_high and gcd_target; rsp_o
// returns pair_count and range_error, one response per request, in order.
// Both are valid/ready; a transfer happens when valid and ready are high.
// Reset: after rst_ni releases, the sieve fills the mertens ram. It clears
// the moebius table, scans the numbers for primes and sweeps each prime's
// multiples, then writes the prefix sums. req_i.ready stays low
// throughout.
// Query: a query runs four corners; each corner takes two divisions plus,
// per block of equal quotients, four divisions and two ram reads. Every
// division uses the one shared divider, and a corner runs up to
// 2*(sqrt(X/g)+sqrt(Y/g)) blocks. Range errors skip the corners and go
// straight to the output register.
// Throughput: one query at a time; ready rises again once the result has
// moved into the output register, so a stalled receiver blocks only the next
// result, not the next request.
`default_nettype none

module gcd_pair_counter_core #(
  parameter int unsigned MAX_VALUE   = 65535,
  parameter int unsigned PRIME_SLOTS = 8192
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  gcdpc_req_if.sink    req_i,
  gcdpc_rsp_if.source  rsp_o
);

  localparam int unsigned VW = $clog2(MAX_VALUE + 1);
  localparam int unsigned MW = VW + 1;

  logic                 table_ok;
  logic                 mrt_we;
  logic [VW-1:0]        mrt_waddr;
  logic signed [MW-1:0] mrt_wdata;
  logic [VW-1:0]        mrt_raddr;
  logic [MW-1:0]        mrt_rdata;

  // table builder
  gcdpc_sieve #(
    .MAX_VALUE  (MAX_VALUE),
    .PRIME_SLOTS(PRIME_SLOTS)
  ) u_sieve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .done_o     (table_ok),
    .mrt_we_o   (mrt_we),
    .mrt_addr_o (mrt_waddr),
    .mrt_wdata_o(mrt_wdata)
  );

  // mertens prefix table
  gcdpc_ram #(
    .Width(MW),
    .Depth(MAX_VALUE + 1)
  ) u_mrt_ram (
    .clk_i  (clk_i),
    .we_i   (mrt_we),
    .waddr_i(mrt_waddr),
    .wdata_i(mrt_wdata),
    .raddr_i(mrt_raddr),
    .rdata_o(mrt_rdata)
  );

  // query engine
  gcdpc_query #(
    .MAX_VALUE(MAX_VALUE)
  ) u_query (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .table_ok_i (table_ok),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .mrt_addr_o (mrt_raddr),
    .mrt_rdata_i(signed'(mrt_rdata))
  );

endmodule

`default_nettype wire

>>> sv/gcdpc_checker.sv
// port-level checks of the gcd pair counter, bound to the top level
// depends on gcd_pair_counter_core_defines.svh
`default_nettype none
`include "gcd_pair_counter_core_defines.svh"

module gcdpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] pair_count_i,
  input wire logic        range_error_i
);

  // a pending response is held until its transfer
  `GCDPC_ASSERT_NEXT(a_rsp_hold, out_valid_i && !out_ready_i, out_valid_i, "response dropped")

  // an error response carries a zero count
  `GCDPC_ASSERT_IMPL(a_err_zero, out_valid_i && range_error_i, pair_count_i == 32'd0, "error count")

  // a request transfer makes the block busy
  `GCDPC_ASSERT_NEXT(a_busy, in_valid_i && in_ready_i, !in_ready_i, "ready after transfer")

  // no request is taken as reset releases, when the table build begins
  `GCDPC_ASSERT_IMPL(a_boot, $rose(rst_ni), !in_ready_i, "ready during table build")

endmodule

bind gcd_pair_counter_core gcdpc_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .pair_count_i (rsp_o.pair_count),
  .range_error_i(rsp_o.range_error)
);

`default_nettype wire
